@@ design/frame_section_reassembly_controller_unit_assert.svh @@
// assertion macros shared by the reassembly controller checker
// no dependencies; every macro reports through $error
`ifndef FRAME_SECTION_REASSEMBLY_CONTROLLER_UNIT_ASSERT_SVH
`define FRAME_SECTION_REASSEMBLY_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define FSRC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/fsrc_pkg.sv @@
// shared types and constants of the frame section reassembly controller
// no dependencies
package fsrc_pkg;

   localparam int HEADER_BYTES = 7;

   localparam int LEVEL_W = 4;
   localparam int SIZE_W  = 25;
   localparam int MASK_W  = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [SIZE_W-1:0] BYTE_MAX = {SIZE_W{1'b1}};

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_LEVEL      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_BUFFER_SIZE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_MASK         = 2'd2;

   // reset values of the configuration registers
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd3;
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 25'd65536;
   localparam logic [MASK_W-1:0]  MASK_RESET  = 8'd0;

   // result status codes
   localparam logic [2:0] ST_ERROR    = 3'd0;
   localparam logic [2:0] ST_CLOSED   = 3'd1;
   localparam logic [2:0] ST_OVERFLOW = 3'd2;
   localparam logic [2:0] ST_STORED   = 3'd3;
   localparam logic [2:0] ST_COMPLETE = 3'd4;

   typedef struct packed {
      logic [7:0]        frame_number;
      logic [7:0]        sect_count;
      logic [SIZE_W-1:0] byte_count;
   } slot_entry_type;

endpackage

@@ design/fsrc_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
module fsrc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/frame_section_reassembly_controller_unit.sv @@
// frame section reassembly controller: slot selection and count update per section header
// depends on fsrc_pkg and fsrc_ram
//
// channel  | ports                          | handshake
// ---------+--------------------------------+-------------------------------------
// request  | req_* fields                   | beat taken when start && !busy
// response | rsp_* fields                   | rsp_valid for one cycle, no back-pressure
// config   | csr_wr_en, csr_index, csr_wdata| written on any edge with csr_wr_en
//
// an error, short or closed-stream beat answers in the next cycle and leaves busy low
// a stored beat runs the slot modulo through a 2-bit-per-cycle remainder unit (S_DIV),
// then S_ADJ for slot choice and memory read and S_UPD for the count update; busy stays
// high through these states, and the next beat can be taken while the result is shown
// reset is synchronous; slot state has valid bits cleared by reset or a known register write
// the receiver cannot stall, so a result is never held
module frame_section_reassembly_controller_unit #(
   parameter int MAX_STREAMS = 8,
   parameter int MAX_LEVELS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_receive_error,
   input  logic [15:0] req_datagram_length,
   input  logic [7:0]  req_stream_id,
   input  logic [7:0]  req_frame_number,
   input  logic [7:0]  req_section_total,
   input  logic [23:0] req_byte_offset,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_stream_out,
   output logic [2:0]  rsp_buffer_select,
   output logic [23:0] rsp_write_offset,
   output logic [15:0] rsp_write_length,
   output logic [24:0] rsp_frame_length,
   input  logic        csr_wr_en,
   input  logic [fsrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fsrc_pkg::SIZE_W-1:0]      csr_wdata
);

   localparam int STREAMS_EFF = (MAX_STREAMS < 8) ? MAX_STREAMS : 8;
   localparam int STREAM_W    = (STREAMS_EFF > 1) ? $clog2(STREAMS_EFF) : 1;
   localparam int NSTREAM     = 1 << STREAM_W;
   localparam int LVL_W       = $clog2(MAX_LEVELS);
   localparam int ADDR_W      = STREAM_W + LVL_W;
   localparam int DEPTH       = 1 << ADDR_W;
   localparam int ENTRY_W     = $bits(fsrc_pkg::slot_entry_type);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_ADJ  = 2'd2;
   localparam logic [1:0] S_UPD  = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [3:0]  level_ff, level_in;
   logic [24:0] size_ff, size_in;
   logic [7:0]  mask_ff, mask_in;

   logic [15:0] dlen_ff, dlen_in;
   logic [7:0]  stream_ff, stream_in;
   logic [7:0]  frame_ff, frame_in;
   logic [7:0]  total_ff, total_in;
   logic [23:0] offset_ff, offset_in;
   logic [3:0]  levels_ff, levels_in;
   logic [7:0]  frame_sh_ff, frame_sh_in;
   logic [3:0]  rem_ff, rem_in;
   logic [1:0]  step_ff, step_in;
   logic [LVL_W-1:0] use_ff, use_in;

   logic [DEPTH-1:0]   slot_valid_ff, slot_valid_in;
   logic [NSTREAM-1:0] done_valid_ff, done_valid_in;
   logic [LVL_W-1:0]   done_slot_ff [NSTREAM];
   logic [LVL_W-1:0]   done_slot_in [NSTREAM];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [2:0]  rsp_stream_ff, rsp_stream_in;
   logic [2:0]  rsp_select_ff, rsp_select_in;
   logic [23:0] rsp_offset_ff, rsp_offset_in;
   logic [15:0] rsp_length_ff, rsp_length_in;
   logic [24:0] rsp_frame_ff, rsp_frame_in;

   // memory port
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   fsrc_pkg::slot_entry_type ram_wr_data, ram_rd_data;

   // working signals
   logic              accept, bad_beat, closed_beat, cfg_hit;
   logic [3:0]        levels_eff, divisor;
   logic [4:0]        part_a, part_b;
   logic [3:0]        rem_mid, rem_next;
   logic [STREAM_W-1:0] stream_sel;
   logic [LVL_W-1:0]  use_base, use_next, done_slot;
   logic [LVL_W:0]    use_inc;
   fsrc_pkg::slot_entry_type entry;
   logic [15:0]       data_len;
   logic [24:0]       end_pos;
   logic              overflow, complete;
   logic [7:0]        sc_base, sc_new;
   logic [24:0]       bc_base, bc_new;
   logic [25:0]       bc_sum;

   fsrc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // effective slot count with out-of-range levels clamped
   always_comb begin
      if (level_ff < 4'd2) begin
         levels_eff = 4'd2;
      end else if (int'(level_ff) > MAX_LEVELS) begin
         levels_eff = 4'(MAX_LEVELS);
      end else begin
         levels_eff = level_ff;
      end
   end

   assign bad_beat    = req_receive_error
                        || (req_datagram_length < 16'(fsrc_pkg::HEADER_BYTES));
   assign closed_beat = (int'(req_stream_id) >= STREAMS_EFF)
                        || !mask_ff[req_stream_id[2:0]];

   // remainder unit: two restoring compare-subtract steps per cycle
   assign divisor = levels_ff - 4'd1;
   always_comb begin
      part_a = {rem_ff, frame_sh_ff[7]};
      if (part_a >= {1'b0, divisor}) begin
         part_a = part_a - {1'b0, divisor};
      end
      rem_mid = part_a[3:0];
      part_b  = {rem_mid, frame_sh_ff[6]};
      if (part_b >= {1'b0, divisor}) begin
         part_b = part_b - {1'b0, divisor};
      end
      rem_next = part_b[3:0];
   end

   // slot choice, stepping past the completed slot
   assign stream_sel = stream_ff[STREAM_W-1:0];
   assign use_base   = rem_ff[LVL_W-1:0];
   assign done_slot  = done_slot_ff[stream_sel];
   assign use_inc    = {1'b0, use_base} + {{LVL_W{1'b0}}, 1'b1};
   always_comb begin
      use_next = use_base;
      if (done_valid_ff[stream_sel] && (use_base >= done_slot)) begin
         if (5'(use_inc) >= {1'b0, levels_ff}) begin
            use_next = '0;
         end else begin
            use_next = use_inc[LVL_W-1:0];
         end
      end
   end

   assign ram_rd_en   = (state_ff == S_ADJ);
   assign ram_rd_addr = {stream_sel, use_next};
   assign ram_wr_addr = {stream_sel, use_ff};

   // slot update
   always_comb begin
      entry    = slot_valid_ff[ram_wr_addr] ? ram_rd_data : '0;
      data_len = dlen_ff - 16'(fsrc_pkg::HEADER_BYTES);
      end_pos  = {1'b0, offset_ff} + {9'd0, data_len};
      overflow = end_pos > size_ff;
      if (entry.frame_number == frame_ff) begin
         sc_base = entry.sect_count;
         bc_base = entry.byte_count;
      end else begin
         sc_base = '0;
         bc_base = '0;
      end
      bc_sum = {1'b0, bc_base} + {10'd0, data_len};
      if (overflow) begin
         sc_new = sc_base;
         bc_new = bc_base;
      end else begin
         sc_new = (sc_base == 8'hFF) ? sc_base : sc_base + 8'd1;
         bc_new = bc_sum[25] ? fsrc_pkg::BYTE_MAX : bc_sum[24:0];
      end
      complete = !overflow && (sc_new == total_ff);
      ram_wr_data.frame_number = frame_ff;
      ram_wr_data.sect_count   = sc_new;
      ram_wr_data.byte_count   = bc_new;
   end

   assign ram_wr_en = (state_ff == S_UPD);

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      size_in       = size_ff;
      mask_in       = mask_ff;
      dlen_in       = dlen_ff;
      stream_in     = stream_ff;
      frame_in      = frame_ff;
      total_in      = total_ff;
      offset_in     = offset_ff;
      levels_in     = levels_ff;
      frame_sh_in   = frame_sh_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      use_in        = use_ff;
      slot_valid_in = slot_valid_ff;
      done_valid_in = done_valid_ff;
      done_slot_in  = done_slot_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_stream_in = rsp_stream_ff;
      rsp_select_in = rsp_select_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_length_in = rsp_length_ff;
      rsp_frame_in  = rsp_frame_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dlen_in     = req_datagram_length;
               stream_in   = req_stream_id;
               frame_in    = req_frame_number;
               total_in    = req_section_total;
               offset_in   = req_byte_offset;
               levels_in   = levels_eff;
               frame_sh_in = req_frame_number;
               rem_in      = '0;
               step_in     = '0;
               if (bad_beat || closed_beat) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bad_beat ? fsrc_pkg::ST_ERROR : fsrc_pkg::ST_CLOSED;
                  rsp_stream_in = req_stream_id[2:0];
                  rsp_select_in = '0;
                  rsp_offset_in = '0;
                  rsp_length_in = '0;
                  rsp_frame_in  = '0;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            rem_in      = rem_next;
            frame_sh_in = {frame_sh_ff[5:0], 2'b00};
            step_in     = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = S_ADJ;
            end
         end
         S_ADJ: begin
            use_in   = use_next;
            state_in = S_UPD;
         end
         S_UPD: begin
            slot_valid_in[ram_wr_addr] = 1'b1;
            if (complete) begin
               done_valid_in[stream_sel] = 1'b1;
               done_slot_in[stream_sel]  = use_ff;
            end
            rsp_valid_in  = 1'b1;
            if (overflow) begin
               rsp_status_in = fsrc_pkg::ST_OVERFLOW;
            end else if (complete) begin
               rsp_status_in = fsrc_pkg::ST_COMPLETE;
            end else begin
               rsp_status_in = fsrc_pkg::ST_STORED;
            end
            rsp_stream_in = stream_ff[2:0];
            rsp_select_in = 3'(use_ff);
            rsp_offset_in = offset_ff;
            rsp_length_in = data_len;
            rsp_frame_in  = bc_new;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes; any known register clears all slot state
      cfg_hit = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            fsrc_pkg::CSR_BUFFER_LEVEL: begin
               level_in = csr_wdata[3:0];
               cfg_hit  = 1'b1;
            end
            fsrc_pkg::CSR_FRAME_BUFFER_SIZE: begin
               size_in = csr_wdata;
               cfg_hit = 1'b1;
            end
            fsrc_pkg::CSR_OPEN_MASK: begin
               mask_in = csr_wdata[7:0];
               cfg_hit = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
      if (cfg_hit) begin
         slot_valid_in = '0;
         done_valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         level_ff      <= fsrc_pkg::LEVEL_RESET;
         size_ff       <= fsrc_pkg::SIZE_RESET;
         mask_ff       <= fsrc_pkg::MASK_RESET;
         slot_valid_ff <= '0;
         done_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         level_ff      <= level_in;
         size_ff       <= size_in;
         mask_ff       <= mask_in;
         slot_valid_ff <= slot_valid_in;
         done_valid_ff <= done_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dlen_ff       <= dlen_in;
      stream_ff     <= stream_in;
      frame_ff      <= frame_in;
      total_ff      <= total_in;
      offset_ff     <= offset_in;
      levels_ff     <= levels_in;
      frame_sh_ff   <= frame_sh_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      use_ff        <= use_in;
      done_slot_ff  <= done_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_stream_ff <= rsp_stream_in;
      rsp_select_ff <= rsp_select_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_length_ff <= rsp_length_in;
      rsp_frame_ff  <= rsp_frame_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_stream_out    = rsp_stream_ff;
   assign rsp_buffer_select = rsp_select_ff;
   assign rsp_write_offset  = rsp_offset_ff;
   assign rsp_write_length  = rsp_length_ff;
   assign rsp_frame_length  = rsp_frame_ff;

endmodule

@@ design/fsrc_checker.sv @@
// port-level checks on the reassembly controller, bound to the top level
// depends on fsrc_pkg and frame_section_reassembly_controller_unit_assert.svh
`include "frame_section_reassembly_controller_unit_assert.svh"

module fsrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [2:0]  rsp_buffer_select,
   input logic [23:0] rsp_write_offset,
   input logic [15:0] rsp_write_length,
   input logic [24:0] rsp_frame_length
);

   logic dropped, stored, known, no_place, covers;

   assign dropped  = (rsp_status == fsrc_pkg::ST_ERROR)
                     || (rsp_status == fsrc_pkg::ST_CLOSED);
   assign stored   = (rsp_status == fsrc_pkg::ST_STORED)
                     || (rsp_status == fsrc_pkg::ST_COMPLETE);
   assign known    = dropped || stored || (rsp_status == fsrc_pkg::ST_OVERFLOW);
   assign no_place = (rsp_buffer_select == 3'd0) && (rsp_write_offset == 24'd0)
                     && (rsp_write_length == 16'd0) && (rsp_frame_length == 25'd0);
   assign covers   = rsp_frame_length >= {9'd0, rsp_write_length};

   // a taken beat either answers at once or keeps the block busy
   `FSRC_ASSERT_NEXT(a_beat_progress, clock, reset, start && !busy, rsp_valid || busy, "beat lost")

   `FSRC_ASSERT_IMPLY(a_status_range, clock, reset, rsp_valid, known, "bad status")

   // rejected beats carry no placement
   `FSRC_ASSERT_IMPLY(a_drop_zero, clock, reset, rsp_valid && dropped, no_place, "drop with payload")

   // the slot holds at least this beat's bytes once stored
   `FSRC_ASSERT_IMPLY(a_frame_covers, clock, reset, rsp_valid && stored, covers, "frame length short")

endmodule

bind frame_section_reassembly_controller_unit fsrc_checker u_fsrc_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// testbench for frame_section_reassembly_controller_unit: directed and random section headers,
// each result beat checked against a slot-tracking model; depends on fsrc_pkg and the design
module tb;

   localparam int STREAMS = 8;
   localparam int LEVELS = 8;
   localparam int DATA_W = fsrc_pkg::SIZE_W;
   localparam logic [3:0] NO_SLOT = 4'hf;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic        receive_error;
      logic [15:0] datagram_length;
      logic [7:0]  stream_id;
      logic [7:0]  frame_number;
      logic [7:0]  section_total;
      logic [23:0] byte_offset;
   } section_hdr_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  stream;
      logic [2:0]  slot;
      logic [23:0] offset;
      logic [15:0] length;
      logic [24:0] frame_bytes;
   } placement_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_receive_error = 1'b0;
   logic [15:0] req_datagram_length = '0;
   logic [7:0] req_stream_id = '0;
   logic [7:0] req_frame_number = '0;
   logic [7:0] req_section_total = '0;
   logic [23:0] req_byte_offset = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [2:0] rsp_stream_out;
   logic [2:0] rsp_buffer_select;
   logic [23:0] rsp_write_offset;
   logic [15:0] rsp_write_length;
   logic [24:0] rsp_frame_length;
   logic csr_wr_en = 1'b0;
   logic [fsrc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [fsrc_pkg::SIZE_W-1:0] csr_wdata = '0;

   frame_section_reassembly_controller_unit uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_receive_error(req_receive_error),
      .req_datagram_length(req_datagram_length),
      .req_stream_id(req_stream_id),
      .req_frame_number(req_frame_number),
      .req_section_total(req_section_total),
      .req_byte_offset(req_byte_offset),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_stream_out(rsp_stream_out),
      .rsp_buffer_select(rsp_buffer_select),
      .rsp_write_offset(rsp_write_offset),
      .rsp_write_length(rsp_write_length),
      .rsp_frame_length(rsp_frame_length),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // model copy of registers and slot table
   logic [fsrc_pkg::LEVEL_W-1:0] m_level;
   logic [fsrc_pkg::SIZE_W-1:0] m_size;
   logic [fsrc_pkg::MASK_W-1:0] m_mask;
   logic [7:0] m_frame [STREAMS*LEVELS];
   logic [7:0] m_sections [STREAMS*LEVELS];
   logic [fsrc_pkg::SIZE_W-1:0] m_bytes [STREAMS*LEVELS];
   logic [3:0] m_done [STREAMS];

   placement_type pending_placements[$];
   logic [7:0] cur_frame [STREAMS];
   int mismatches = 0;
   int cycles = 0;
   int idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void clear_slots();
      for (int i = 0; i < STREAMS*LEVELS; i++) begin
         m_frame[i] = '0;
         m_sections[i] = '0;
         m_bytes[i] = '0;
      end
      for (int s = 0; s < STREAMS; s++) m_done[s] = NO_SLOT;
   endfunction

   // slot choice and count update for one accepted header
   function automatic placement_type place_section(section_hdr_type h);
      placement_type p;
      int levels, slot_no, idx;
      longint data, sum;
      p = '0;
      p.stream = h.stream_id[2:0];
      if (h.receive_error || h.datagram_length < fsrc_pkg::HEADER_BYTES) begin
         p.status = fsrc_pkg::ST_ERROR;
         return p;
      end
      if (h.stream_id >= STREAMS || !m_mask[h.stream_id[2:0]]) begin
         p.status = fsrc_pkg::ST_CLOSED;
         return p;
      end
      levels = m_level;
      if (levels < 2) levels = 2;
      if (levels > LEVELS) levels = LEVELS;
      slot_no = h.frame_number % (levels - 1);
      // step past the slot holding the last completed frame
      if (m_done[h.stream_id] != NO_SLOT && slot_no >= m_done[h.stream_id]) begin
         slot_no++;
         if (slot_no >= levels) slot_no = 0;
      end
      idx = h.stream_id * LEVELS + slot_no;
      if (m_frame[idx] != h.frame_number) begin
         m_frame[idx] = h.frame_number;
         m_sections[idx] = '0;
         m_bytes[idx] = '0;
      end
      data = h.datagram_length - fsrc_pkg::HEADER_BYTES;
      if (longint'(h.byte_offset) + data > longint'(m_size)) begin
         p.status = fsrc_pkg::ST_OVERFLOW;
      end else begin
         if (m_sections[idx] != 8'hff) m_sections[idx]++;
         sum = longint'(m_bytes[idx]) + data;
         m_bytes[idx] = (sum > longint'(fsrc_pkg::BYTE_MAX)) ? fsrc_pkg::BYTE_MAX
                                                              : DATA_W'(sum);
         p.status = fsrc_pkg::ST_STORED;
         if (m_sections[idx] == h.section_total) begin
            m_done[h.stream_id] = 4'(slot_no);
            p.status = fsrc_pkg::ST_COMPLETE;
         end
      end
      p.slot = 3'(slot_no);
      p.offset = h.byte_offset;
      p.length = 16'(data);
      p.frame_bytes = m_bytes[idx];
      return p;
   endfunction

   task automatic note_mismatch(input string what, input placement_type want,
                                input placement_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected st %0d str %0d slot %0d off %0d len %0d bytes %0d",
                  what, want.status, want.stream, want.slot, want.offset, want.length,
                  want.frame_bytes);
         $display("   got st %0d str %0d slot %0d off %0d len %0d bytes %0d",
                  got.status, got.stream, got.slot, got.offset, got.length, got.frame_bytes);
      end
   endtask

   always @(posedge clock) begin : check_results
      placement_type want;
      placement_type got;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_stream_out, rsp_buffer_select, rsp_write_offset,
                rsp_write_length, rsp_frame_length};
         if (pending_placements.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_placements.pop_front();
            if (got.status !== want.status || got.stream !== want.stream ||
                got.slot !== want.slot || got.offset !== want.offset ||
                got.length !== want.length || got.frame_bytes !== want.frame_bytes)
               note_mismatch("result mismatch", want, got);
         end
      end
   end

   // one request beat; start stays high unless an idle gap is taken
   task automatic send_section(input section_hdr_type h);
      int gap;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_receive_error <= h.receive_error;
      req_datagram_length <= h.datagram_length;
      req_stream_id <= h.stream_id;
      req_frame_number <= h.frame_number;
      req_section_total <= h.section_total;
      req_byte_offset <= h.byte_offset;
      do @(posedge clock); while (busy);
      pending_placements.push_back(place_section(h));
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [fsrc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [fsrc_pkg::SIZE_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         fsrc_pkg::CSR_BUFFER_LEVEL: m_level = val[fsrc_pkg::LEVEL_W-1:0];
         fsrc_pkg::CSR_FRAME_BUFFER_SIZE: m_size = val;
         fsrc_pkg::CSR_OPEN_MASK: m_mask = val[fsrc_pkg::MASK_W-1:0];
         default: ;
      endcase
      clear_slots();
      @(posedge clock);
   endtask

   task automatic configure(input logic [fsrc_pkg::LEVEL_W-1:0] level,
                            input logic [fsrc_pkg::SIZE_W-1:0] size,
                            input logic [fsrc_pkg::MASK_W-1:0] mask);
      settle();
      write_reg(fsrc_pkg::CSR_BUFFER_LEVEL, DATA_W'(level));
      write_reg(fsrc_pkg::CSR_FRAME_BUFFER_SIZE, size);
      write_reg(fsrc_pkg::CSR_OPEN_MASK, DATA_W'(mask));
   endtask

   function automatic section_hdr_type hdr(input logic err, input logic [15:0] dlen,
                                           input logic [7:0] stream, input logic [7:0] frame,
                                           input logic [7:0] total, input logic [23:0] offset);
      return '{err, dlen, stream, frame, total, offset};
   endfunction

   // mostly well-formed sections on a few frames per stream, with some noise
   function automatic section_hdr_type random_section();
      section_hdr_type h;
      int r, s, room;
      longint data, span;
      r = $urandom_range(99);
      if (r < 8)
         return hdr(1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    24'($urandom));
      s = $urandom_range(STREAMS - 1);
      if ($urandom_range(99) < 15)
         cur_frame[s] = ($urandom_range(3) == 0) ? 8'($urandom) : cur_frame[s] + 8'd1;
      room = (m_size > 2000) ? 2000 : int'(m_size);
      data = $urandom_range(0, room);
      span = longint'(m_size) - data;
      if (span > 24'hffffff) span = 24'hffffff;
      h = hdr(1'b0, 16'(fsrc_pkg::HEADER_BYTES + data), 8'(s), cur_frame[s],
              8'($urandom_range(1, 4)), 24'($urandom_range(0, int'(span))));
      if (r < 12) h.section_total = 8'($urandom);
      else if (r < 16) h.byte_offset = 24'($urandom);
      else if (r < 18) h.receive_error = 1'b1;
      else if (r < 20)
         h.datagram_length = 16'($urandom_range(0, fsrc_pkg::HEADER_BYTES - 1));
      return h;
   endfunction

   task automatic test_reset_state();
      // all streams closed after reset
      send_section(hdr(1'b0, 16'd100, 8'd0, 8'd1, 8'd1, 24'd0));
      send_section(hdr(1'b1, 16'd100, 8'd3, 8'd1, 8'd1, 24'd0));
      send_section(hdr(1'b0, 16'd6, 8'd5, 8'd1, 8'd1, 24'd0));
   endtask

   task automatic test_header_checks();
      configure(fsrc_pkg::LEVEL_RESET, fsrc_pkg::SIZE_RESET, 8'hff);
      send_section(hdr(1'b1, 16'hffff, 8'd1, 8'hff, 8'hff, 24'hffffff));
      send_section(hdr(1'b0, 16'd0, 8'd1, 8'd2, 8'd1, 24'd0));
      send_section(hdr(1'b0, 16'd7, 8'd1, 8'd2, 8'd1, 24'd0));
      send_section(hdr(1'b0, 16'd50, 8'd8, 8'd2, 8'd1, 24'd0));
      send_section(hdr(1'b0, 16'd50, 8'hff, 8'd2, 8'd1, 24'd0));
      send_section(hdr(1'b0, 16'hffff, 8'd7, 8'd3, 8'd0, 24'd8));
      send_section(hdr(1'b0, 16'hffff, 8'd7, 8'd3, 8'd0, 24'd9));
      send_section(hdr(1'b0, 16'd8, 8'd6, 8'd0, 8'd0, 24'hffffff));
   endtask

   task automatic test_completion();
      configure(4'd3, fsrc_pkg::SIZE_RESET, 8'h04);
      send_section(hdr(1'b0, 16'd107, 8'd2, 8'd4, 8'd2, 24'd0));
      send_section(hdr(1'b0, 16'd57, 8'd2, 8'd4, 8'd2, 24'd100));
      send_section(hdr(1'b0, 16'd20, 8'd2, 8'd5, 8'd1, 24'd0));
      send_section(hdr(1'b0, 16'd20, 8'd2, 8'd6, 8'd1, 24'd0));
      // repeat of a completed frame and an overflow on a frame change
      send_section(hdr(1'b0, 16'd20, 8'd2, 8'd6, 8'd1, 24'd20));
      send_section(hdr(1'b0, 16'd20, 8'd2, 8'd9, 8'd1, 24'd65530));
      send_section(hdr(1'b0, 16'd20, 8'd3, 8'd9, 8'd1, 24'd0));
   endtask

   task automatic test_level_and_size_extremes();
      configure(4'd0, '0, 8'h5a);
      send_section(hdr(1'b0, 16'd7, 8'd1, 8'd7, 8'd1, 24'd0));
      send_section(hdr(1'b0, 16'd8, 8'd3, 8'd7, 8'd1, 24'd0));
      configure(4'd15, fsrc_pkg::BYTE_MAX, 8'hff);
      send_section(hdr(1'b0, 16'hffff, 8'd0, 8'd13, 8'd1, 24'hffffff));
      send_section(hdr(1'b0, 16'd30, 8'd0, 8'd14, 8'd2, 24'd0));
      configure(4'd1, 25'd1, 8'hff);
      send_section(hdr(1'b0, 16'd8, 8'd4, 8'd3, 8'd1, 24'd0));
      send_section(hdr(1'b0, 16'd8, 8'd4, 8'd3, 8'd2, 24'd1));
      configure(4'd8, 25'd16777216, 8'hff);
      send_section(hdr(1'b0, 16'd40, 8'd5, 8'd20, 8'd1, 24'd0));
      send_section(hdr(1'b0, 16'd40, 8'd5, 8'd27, 8'd1, 24'd16777176));
   endtask

   // one frame far past 255 sections so the section count runs into its ceiling
   task automatic test_count_saturation();
      configure(4'd8, 25'd16777216, 8'h01);
      for (int i = 0; i < 520; i++)
         send_section(hdr(1'b0, 16'hffff, 8'd0, 8'd9, 8'hff,
                          24'($urandom_range(0, 16777216 - 65528))));
   endtask

   task automatic random_config();
      logic [fsrc_pkg::SIZE_W-1:0] size;
      logic [fsrc_pkg::MASK_W-1:0] mask;
      case ($urandom_range(5))
         0: size = 25'd1;
         1: size = fsrc_pkg::SIZE_RESET;
         2: size = 25'($urandom_range(64, 4096));
         3: size = 25'd16777216;
         4: size = fsrc_pkg::BYTE_MAX;
         default: size = 25'($urandom_range(256, 20000));
      endcase
      mask = ($urandom_range(2) == 0) ? 8'($urandom) : 8'hff;
      configure(4'($urandom_range(15)), size, mask);
   endtask

   task automatic test_random_traffic();
      int pct [3] = '{15, 48, 0};
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = pct[phase];
         for (int seg = 0; seg < 6; seg++) begin
            random_config();
            for (int n = 0; n < 20; n++) send_section(random_section());
         end
      end
   endtask

   initial begin
      m_level = fsrc_pkg::LEVEL_RESET;
      m_size = fsrc_pkg::SIZE_RESET;
      m_mask = fsrc_pkg::MASK_RESET;
      clear_slots();
      for (int s = 0; s < STREAMS; s++) cur_frame[s] = 8'($urandom);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_header_checks();
      test_completion();
      test_level_and_size_extremes();
      test_count_saturation();
      test_random_traffic();
      settle();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
